[src/tpc_pkg.sv]
package tpc_pkg;

  typedef enum logic [1:0] {
    KIND_CULL = 2'd0,
    KIND_PASS = 2'd1,
    KIND_ONE  = 2'd2,
    KIND_TWO  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    REG_PP_X = 3'd0,
    REG_PP_Y = 3'd1,
    REG_PP_Z = 3'd2,
    REG_N_X  = 3'd3,
    REG_N_Y  = 3'd4,
    REG_N_Z  = 3'd5
  } cfg_reg_e;

  // Endpoints of the pair of edges that cross the plane: inside vertex, outside vertex.
  typedef struct packed {
    logic [1:0] ia0;
    logic [1:0] ob0;
    logic [1:0] ia1;
    logic [1:0] ob1;
  } pair_t;

  typedef struct packed {
    kind_e      kind;
    logic [1:0] in0;
    logic [1:0] in1;
    pair_t      pairs;
  } route_t;

  // Width of a saturated plane distance.
  function automatic int dist_w(int w, int f);
    int s;
    s = 2 * w + 3 - f;
    return (s > 64) ? 64 : s;
  endfunction

  // ins bit i is set when vertex i lies on the inside of the plane.
  function automatic route_t route_of(logic [2:0] ins);
    route_t r;
    r = '0;
    case (ins)
      3'b000:  r.kind = KIND_CULL;
      3'b111:  r.kind = KIND_PASS;
      3'b001: begin
        r.kind = KIND_ONE; r.in0 = 2'd0;
        r.pairs = '{ia0: 2'd0, ob0: 2'd1, ia1: 2'd0, ob1: 2'd2};
      end
      3'b010: begin
        r.kind = KIND_ONE; r.in0 = 2'd1;
        r.pairs = '{ia0: 2'd1, ob0: 2'd0, ia1: 2'd1, ob1: 2'd2};
      end
      3'b100: begin
        r.kind = KIND_ONE; r.in0 = 2'd2;
        r.pairs = '{ia0: 2'd2, ob0: 2'd0, ia1: 2'd2, ob1: 2'd1};
      end
      3'b011: begin
        r.kind = KIND_TWO; r.in0 = 2'd0; r.in1 = 2'd1;
        r.pairs = '{ia0: 2'd0, ob0: 2'd2, ia1: 2'd1, ob1: 2'd2};
      end
      3'b101: begin
        r.kind = KIND_TWO; r.in0 = 2'd0; r.in1 = 2'd2;
        r.pairs = '{ia0: 2'd0, ob0: 2'd1, ia1: 2'd2, ob1: 2'd1};
      end
      default: begin
        r.kind = KIND_TWO; r.in0 = 2'd1; r.in1 = 2'd2;
        r.pairs = '{ia0: 2'd1, ob0: 2'd0, ia1: 2'd2, ob1: 2'd0};
      end
    endcase
    return r;
  endfunction

endpackage

[src/triangle_plane_clip.sv]
// Channel   Dir  Handshake                 Payload
// s_axis    in   tvalid/tready             tdata: a, b, c vertices, tri_colour
// m_axis    out  tvalid/tready             tdata: out vertices, out_colour;
//                                          tuser: clip_kind; tlast: last_of_run
// apb       in   psel/penable/pwrite       six plane registers, pready tied high
//
// From input to first result there are four distance stages, COORD_WIDTH + 5
// crossing stages (the division stages among them give one quotient bit each)
// and the output register. An item that gives one result takes one beat of the
// result port, an item clipped to two triangles takes two. The whole pipeline
// moves on one enable and holds while the output register keeps an undelivered
// result. Reset touches only valid bits, the beat flag and configuration registers.
module triangle_plane_clip #(
  parameter int  COORD_WIDTH = 32,
  parameter int  FRAC_BITS   = 16,
  localparam int TDW         = ((9 * COORD_WIDTH + 24 + 7) / 8) * 8,
  localparam int PDW         = (COORD_WIDTH > 32) ? 64 : 32,
  localparam int AW          = ((COORD_WIDTH > 32) ? 3 : 2) + 3
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, tri_colour
  input  logic [TDW-1:0] s_axis_tdata,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  // out_a_x .. out_c_z, out_colour
  output logic [TDW-1:0] m_axis_tdata,
  // clip_kind
  output logic [1:0]     m_axis_tuser,
  output logic           m_axis_tlast,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [AW-1:0]  paddr,
  input  logic [PDW-1:0] pwdata,
  output logic [PDW-1:0] prdata,
  output logic           pready
);
  import tpc_pkg::*;

  localparam int W      = COORD_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int DW     = dist_w(W, F);
  localparam int DL     = 4;
  localparam int CL     = W + 5;
  localparam int STRIDE = AW - 3;
  localparam logic [W-1:0] PPZ_RST = W'((2 ** F + 5) / 10);
  localparam logic [W-1:0] NZ_RST  = W'(2 ** F);

  typedef struct packed {
    logic [2:0][2:0][W-1:0] v;
    logic [23:0]            colour;
  } front_t;

  typedef struct packed {
    logic [2:0][2:0][W-1:0] v;
    logic [23:0]            colour;
    route_t                 rt;
  } back_t;

  // Configuration.
  logic [2:0][W-1:0] pp_q, n_q;
  logic              cfg_wr;
  cfg_reg_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = cfg_reg_e'(paddr[AW-1:STRIDE]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_q <= {PPZ_RST, {W{1'b0}}, {W{1'b0}}};
      n_q  <= {NZ_RST, {W{1'b0}}, {W{1'b0}}};
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PP_X: pp_q[0] <= pwdata[W-1:0];
        REG_PP_Y: pp_q[1] <= pwdata[W-1:0];
        REG_PP_Z: pp_q[2] <= pwdata[W-1:0];
        REG_N_X:  n_q[0]  <= pwdata[W-1:0];
        REG_N_Y:  n_q[1]  <= pwdata[W-1:0];
        REG_N_Z:  n_q[2]  <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_PP_X: prdata = PDW'($signed(pp_q[0]));
      REG_PP_Y: prdata = PDW'($signed(pp_q[1]));
      REG_PP_Z: prdata = PDW'($signed(pp_q[2]));
      REG_N_X:  prdata = PDW'($signed(n_q[0]));
      REG_N_Y:  prdata = PDW'($signed(n_q[1]));
      REG_N_Z:  prdata = PDW'($signed(n_q[2]));
      default:  prdata = '0;
    endcase
  end

  // Pipeline.
  logic                   adv;
  front_t                 front_in;
  front_t                 front_q [DL];
  back_t                  back_q  [CL];
  logic [DL-1:0]          vld_f_q;
  logic [CL-1:0]          vld_b_q;
  logic [DW-1:0]          vdist [3];
  logic [2:0]             ins;
  route_t                 rt;
  logic [1:0]             ia [2];
  logic [1:0]             ob [2];
  logic [1:0][2:0][W-1:0] xres;

  assign front_in.v      = s_axis_tdata[9*W-1:0];
  assign front_in.colour = s_axis_tdata[9*W +: 24];

  for (genvar i = 0; i < 3; i++) begin : g_dist
    tpc_dist_lane #(.COORD_WIDTH(W), .FRAC_BITS(F)) u_dist (
      .clk_i  (clk_i),
      .en_i   (adv),
      .p_i    (front_in.v[i]),
      .pp_i   (pp_q),
      .n_i    (n_q),
      .dist_o (vdist[i])
    );
    assign ins[i] = ~vdist[i][DW-1];
  end

  assign rt    = route_of(ins);
  assign ia[0] = rt.pairs.ia0;
  assign ob[0] = rt.pairs.ob0;
  assign ia[1] = rt.pairs.ia1;
  assign ob[1] = rt.pairs.ob1;

  for (genvar k = 0; k < 2; k++) begin : g_edge
    for (genvar c = 0; c < 3; c++) begin : g_comp
      tpc_cross_lane #(.COORD_WIDTH(W), .FRAC_BITS(F)) u_cross (
        .clk_i (clk_i),
        .en_i  (adv),
        .a_i   (front_q[DL-1].v[ia[k]][c]),
        .b_i   (front_q[DL-1].v[ob[k]][c]),
        .da_i  (vdist[ia[k]]),
        .db_i  (vdist[ob[k]]),
        .x_o   (xres[k][c])
      );
    end
  end

  // Output register and beat control.
  logic                   job_v_q, beat_q;
  back_t                  job_q;
  logic [1:0][2:0][W-1:0] jx_q;
  logic [2:0][2:0][W-1:0] ov;

  assign adv           = !job_v_q || (m_axis_tready && m_axis_tlast);
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_f_q <= '0;
      vld_b_q <= '0;
      job_v_q <= 1'b0;
      beat_q  <= 1'b0;
    end else if (adv) begin
      vld_f_q <= {vld_f_q[DL-2:0], s_axis_tvalid};
      vld_b_q <= {vld_b_q[CL-2:0], vld_f_q[DL-1]};
      job_v_q <= vld_b_q[CL-1];
      beat_q  <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      beat_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      front_q[0] <= front_in;
      for (int s = 1; s < DL; s++) front_q[s] <= front_q[s-1];
      back_q[0] <= '{v: front_q[DL-1].v, colour: front_q[DL-1].colour, rt: rt};
      for (int s = 1; s < CL; s++) back_q[s] <= back_q[s-1];
      job_q <= back_q[CL-1];
      jx_q  <= xres;
    end
  end

  always_comb begin
    case (job_q.rt.kind)
      KIND_CULL: ov = '0;
      KIND_PASS: ov = job_q.v;
      KIND_ONE:  ov = {jx_q[1], jx_q[0], job_q.v[job_q.rt.in0]};
      default: begin
        // The second triangle reuses the crossing on the first edge.
        if (beat_q) ov = {jx_q[1], jx_q[0], job_q.v[job_q.rt.in1]};
        else        ov = {jx_q[0], job_q.v[job_q.rt.in1], job_q.v[job_q.rt.in0]};
      end
    endcase
  end

  assign m_axis_tvalid = job_v_q;
  assign m_axis_tdata  = TDW'({job_q.colour, ov});
  assign m_axis_tuser  = job_q.rt.kind;
  assign m_axis_tlast  = (job_q.rt.kind == KIND_TWO) ? beat_q : 1'b1;

endmodule

[src/tpc_dist_lane.sv]
module tpc_dist_lane #(
  parameter int  COORD_WIDTH = 32,
  parameter int  FRAC_BITS   = 16,
  localparam int DW          = tpc_pkg::dist_w(COORD_WIDTH, FRAC_BITS)
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [2:0][COORD_WIDTH-1:0]      p_i,
  input  logic [2:0][COORD_WIDTH-1:0]      pp_i,
  input  logic [2:0][COORD_WIDTH-1:0]      n_i,
  output logic signed [DW-1:0]             dist_o
);
  import tpc_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int DFW = W + 1;
  localparam int LO  = DFW / 2;
  localparam int HI  = DFW - LO;
  localparam int PW  = 2 * W + 1;
  localparam int SW  = 2 * W + 3;

  logic signed [DFW-1:0]  diff_q [3];
  logic signed [W+LO:0]   plo_q  [3];
  logic signed [W+HI-1:0] phi_q  [3];
  logic signed [PW-1:0]   prod_q [3];
  logic signed [SW-1:0]   sum, sh;
  logic                   fits;
  logic signed [DW-1:0]   dist_d, dist_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        diff_q[i] <= DFW'($signed(p_i[i])) - DFW'($signed(pp_i[i]));
        // The difference is split in two so that each product stays narrow.
        plo_q[i]  <= $signed(n_i[i]) * $signed({1'b0, diff_q[i][LO-1:0]});
        phi_q[i]  <= $signed(n_i[i]) * $signed(diff_q[i][DFW-1:LO]);
        prod_q[i] <= (PW'(phi_q[i]) <<< LO) + PW'(plo_q[i]);
      end
      dist_q <= dist_d;
    end
  end

  always_comb begin
    sum    = SW'(prod_q[0]) + SW'(prod_q[1]) + SW'(prod_q[2]);
    sh     = sum >>> F;
    fits   = (&sh[SW-1:DW-1]) | ~(|sh[SW-1:DW-1]);
    dist_d = fits ? sh[DW-1:0]
                  : (sum[SW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}});
  end

  assign dist_o = dist_q;

endmodule

[src/tpc_cross_lane.sv]
module tpc_cross_lane #(
  parameter int  COORD_WIDTH = 32,
  parameter int  FRAC_BITS   = 16,
  localparam int DW          = tpc_pkg::dist_w(COORD_WIDTH, FRAC_BITS)
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [COORD_WIDTH-1:0] a_i,
  input  logic [COORD_WIDTH-1:0] b_i,
  input  logic [DW-1:0]          da_i,
  input  logic [DW-1:0]          db_i,
  output logic [COORD_WIDTH-1:0] x_o
);
  import tpc_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int QW  = W + 1;
  localparam int DM  = DW - 1;
  localparam int LO2 = DM / 2;
  localparam int HI2 = DM - LO2;
  localparam int NW  = QW + DM;
  localparam int RW  = DW + 1;

  logic signed [W:0]  diff_d;
  logic [W:0]         mag_q;
  logic               neg1_q, neg2_q;
  logic [DM-1:0]      da_q;
  logic [RW-1:0]      den1_q, den2_q;
  logic [W-1:0]       a1_q, a2_q;
  logic [QW+LO2-1:0]  plo_q;
  logic [QW+HI2-1:0]  phi_q;
  logic [NW-1:0]      num;

  logic [RW-1:0] rem_q [QW+1];
  logic [QW-1:0] low_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic [RW-1:0] den_q [QW+1];
  logic [W-1:0]  a_q   [QW+1];
  logic          neg_q [QW+1];

  logic [W+1:0]  sum_d;
  logic [W-1:0]  x_q;

  assign diff_d = (W+1)'($signed(b_i)) - (W+1)'($signed(a_i));
  assign num    = (NW'(phi_q) << LO2) + NW'(plo_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= diff_d[W] ? -diff_d : diff_d;
      neg1_q <= diff_d[W];
      da_q   <= da_i[DM-1:0];
      den1_q <= {da_i[DW-1], da_i} - {db_i[DW-1], db_i};
      a1_q   <= a_i;

      plo_q  <= mag_q * da_q[LO2-1:0];
      phi_q  <= mag_q * da_q[DM-1:LO2];
      den2_q <= den1_q;
      a2_q   <= a1_q;
      neg2_q <= neg1_q;

      // The quotient never exceeds the coordinate difference, so the upper
      // part of the numerator is already below the divisor.
      rem_q[0] <= RW'(num >> QW);
      low_q[0] <= num[QW-1:0];
      quo_q[0] <= '0;
      den_q[0] <= den2_q;
      a_q[0]   <= a2_q;
      neg_q[0] <= neg2_q;

      x_q <= sum_d[W-1:0];
    end
  end

  // One restoring division step per stage, most significant quotient bit first.
  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [RW-1:0] trial;
    logic          ge;

    assign trial = {rem_q[j][RW-2:0], low_q[j][QW-1-j]};
    assign ge    = (trial >= den_q[j]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1] <= ge ? trial - den_q[j] : trial;
        low_q[j+1] <= low_q[j];
        quo_q[j+1] <= {quo_q[j][QW-2:0], ge};
        den_q[j+1] <= den_q[j];
        a_q[j+1]   <= a_q[j];
        neg_q[j+1] <= neg_q[j];
      end
    end
  end

  assign sum_d = neg_q[QW] ? (W+2)'($signed(a_q[QW])) - (W+2)'(quo_q[QW])
                           : (W+2)'($signed(a_q[QW])) + (W+2)'(quo_q[QW]);

  assign x_o = x_q;

endmodule

[src/tpc_checker.sv]
module tpc_checker #(
  parameter int  COORD_WIDTH = 32,
  localparam int TDW         = ((9 * COORD_WIDTH + 24 + 7) / 8) * 8
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           s_axis_tready,
  input logic           m_axis_tvalid,
  input logic           m_axis_tready,
  input logic [TDW-1:0] m_axis_tdata,
  input logic [1:0]     m_axis_tuser,
  input logic           m_axis_tlast
);
  import tpc_pkg::*;

  localparam int W = COORD_WIDTH;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_cull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_CULL) |->
      m_axis_tlast && (m_axis_tdata[9*W-1:0] == '0))
    else $error("culled result carries vertices or is not last");

  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ((m_axis_tuser == KIND_PASS) || (m_axis_tuser == KIND_ONE))
      |-> m_axis_tlast)
    else $error("single result not marked last");

  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && (m_axis_tuser == KIND_TWO) && !m_axis_tlast
      |=> m_axis_tvalid && (m_axis_tuser == KIND_TWO) && m_axis_tlast)
    else $error("second triangle of a pair missing");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while result is stalled");

endmodule

bind triangle_plane_clip tpc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_tpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
